### rtl/core/forc_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the message FIFO with rate-controlled delay.
// No dependencies; imported by forc_store and the core top level.
package forc_pkg;

	localparam int QUEUE_DEPTH = 32;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int WORD_W      = 32;
	localparam int CNT_W       = 6;
	localparam int THR_W       = 6;
	localparam int DELAY_W     = 24;
	localparam int MODE_W      = 2;
	localparam int STATUS_W    = 2;

	localparam int IN_W  = 40;
	localparam int OUT_W = 64;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	// operation codes
	localparam logic [MODE_W-1:0] MODE_PUT    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_GET    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_ADJUST = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	// register indexes (byte address 4*index)
	localparam logic [2:0] REG_THRESHOLD = 3'd0;
	localparam logic [2:0] REG_STEP      = 3'd1;
	localparam logic [2:0] REG_FLOOR_TRG = 3'd2;
	localparam logic [2:0] REG_FLOOR_VAL = 3'd3;
	localparam logic [2:0] REG_CEILING   = 3'd4;

	localparam logic [THR_W-1:0]   RST_THRESHOLD = 6'd10;
	localparam logic [DELAY_W-1:0] RST_STEP      = 24'd300000;
	localparam logic [DELAY_W-1:0] RST_FLOOR_TRG = 24'd100000;
	localparam logic [DELAY_W-1:0] RST_FLOOR_VAL = 24'd50000;
	localparam logic [DELAY_W-1:0] RST_CEILING   = 24'd2000000;
	localparam logic [DELAY_W-1:0] RST_DELAY     = 24'd500000;

endpackage

### rtl/core/fifo_with_occupancy_rate_control_core.sv
`timescale 1ns / 1ps
// Top level: message FIFO with delay register adjusted by occupancy.
// Depends on forc_pkg and forc_store.
//
// channel  dir  handshake                  payload
// s_*      in   s_tvalid / s_tready        s_tdata: mode, write_word
// m_*      out  m_tvalid / m_tready        m_tdata: read_word, status, occupancy, current_delay
// apb      in   psel/penable/pwrite/pready paddr, pwdata, prdata
//
// m_tvalid follows accept: pointers, count, delay and the memory read register at accept,
// then the output register loads once it is free, and m_tvalid rises with it.
// One item per cycle is sustained while m_tready stays high.
// Reset empties the FIFO, sets the delay to 500000 and loads register defaults.
// A stalled output fills the one-entry stage behind it; s_tready then drops.
module fifo_with_occupancy_rate_control_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [forc_pkg::IN_W-1:0]      s_tdata,  // [1:0] mode, [33:2] write_word
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [forc_pkg::OUT_W-1:0]     m_tdata,  // [31:0] read_word, [33:32] status,
	                                                 // [39:34] occupancy, [63:40] current_delay
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [forc_pkg::ADDR_W-1:0]    paddr,
	input  logic [forc_pkg::DATA_W-1:0]    pwdata,
	output logic [forc_pkg::DATA_W-1:0]    prdata,
	output logic                           pready
);
	import forc_pkg::*;

	// config registers
	logic [THR_W-1:0]   threshold_q;
	logic [DELAY_W-1:0] step_q, floor_trg_q, floor_val_q, ceiling_q;

	logic       cfg_wr;
	logic [2:0] cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= RST_THRESHOLD;
			step_q      <= RST_STEP;
			floor_trg_q <= RST_FLOOR_TRG;
			floor_val_q <= RST_FLOOR_VAL;
			ceiling_q   <= RST_CEILING;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_THRESHOLD: threshold_q <= pwdata[THR_W-1:0];
				REG_STEP:      step_q      <= pwdata[DELAY_W-1:0];
				REG_FLOOR_TRG: floor_trg_q <= pwdata[DELAY_W-1:0];
				REG_FLOOR_VAL: floor_val_q <= pwdata[DELAY_W-1:0];
				REG_CEILING:   ceiling_q   <= pwdata[DELAY_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_THRESHOLD: prdata = {{(DATA_W-THR_W){1'b0}}, threshold_q};
			REG_STEP:      prdata = {{(DATA_W-DELAY_W){1'b0}}, step_q};
			REG_FLOOR_TRG: prdata = {{(DATA_W-DELAY_W){1'b0}}, floor_trg_q};
			REG_FLOOR_VAL: prdata = {{(DATA_W-DELAY_W){1'b0}}, floor_val_q};
			REG_CEILING:   prdata = {{(DATA_W-DELAY_W){1'b0}}, ceiling_q};
			default:       prdata = '0;
		endcase
	end

	// queue state
	logic [PTR_W-1:0]   rd_ptr_q, wr_ptr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [DELAY_W-1:0] delay_q;

	// stage 1 (memory read in flight) and output register
	logic                s1_valid;
	logic                take_word_s1;
	logic [STATUS_W-1:0] status_s1;
	logic [CNT_W-1:0]    occ_s1;
	logic [DELAY_W-1:0]  delay_s1;
	logic                out_valid_q;
	logic [OUT_W-1:0]    out_data_q;

	logic out_free, s1_move, accept;
	assign out_free = !out_valid_q || m_tready;
	assign s1_move  = s1_valid && out_free;
	assign s_tready = !s1_valid || out_free;
	assign accept   = s_tvalid && s_tready;

	logic [MODE_W-1:0] in_mode;
	logic [WORD_W-1:0] in_word;
	assign in_mode = s_tdata[MODE_W-1:0];
	assign in_word = s_tdata[MODE_W +: WORD_W];

	// delay arithmetic, one guard bit for borrow and carry
	logic [DELAY_W:0]   diff, sum;
	logic [DELAY_W-1:0] delay_dec, delay_inc;
	assign diff      = {1'b0, delay_q} - {1'b0, step_q};
	assign sum       = {1'b0, delay_q} + {1'b0, step_q};
	assign delay_dec = (diff[DELAY_W] || diff[DELAY_W-1:0] < floor_trg_q) ? floor_val_q
	                                                                        : diff[DELAY_W-1:0];
	assign delay_inc = (sum > {1'b0, ceiling_q}) ? ceiling_q : sum[DELAY_W-1:0];

	logic                full, empty;
	logic                do_put, do_get;
	logic [STATUS_W-1:0] status_nx;
	logic [CNT_W-1:0]    cnt_nx;
	logic [DELAY_W-1:0]  delay_nx;
	logic [PTR_W-1:0]    rd_ptr_inc, wr_ptr_inc;

	assign full  = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign rd_ptr_inc = (rd_ptr_q == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
	assign wr_ptr_inc = (wr_ptr_q == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;

	always_comb begin
		do_put    = 1'b0;
		do_get    = 1'b0;
		status_nx = ST_DONE;
		cnt_nx    = cnt_q;
		delay_nx  = delay_q;
		case (in_mode)
			MODE_PUT: begin
				if (full) begin
					status_nx = ST_FULL;
				end else begin
					do_put = 1'b1;
					cnt_nx = cnt_q + 1'b1;
				end
			end
			MODE_GET: begin
				if (empty) begin
					status_nx = ST_EMPTY;
				end else begin
					do_get = 1'b1;
					cnt_nx = cnt_q - 1'b1;
				end
			end
			MODE_ADJUST: begin
				delay_nx = (cnt_q < threshold_q) ? delay_dec : delay_inc;
			end
			default: ;  // undefined mode: no operation
		endcase
	end

	logic [WORD_W-1:0] rd_word;

	forc_store u_store (
		.clk   (clk),
		.we    (accept && do_put),
		.waddr (wr_ptr_q),
		.wdata (in_word),
		.re    (accept && do_get),
		.raddr (rd_ptr_q),
		.rdata (rd_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			cnt_q    <= '0;
			delay_q  <= RST_DELAY;
		end else if (accept) begin
			cnt_q   <= cnt_nx;
			delay_q <= delay_nx;
			if (do_put) begin
				wr_ptr_q <= wr_ptr_inc;
			end
			if (do_get) begin
				rd_ptr_q <= rd_ptr_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid <= 1'b1;
			end else if (s1_move) begin
				s1_valid <= 1'b0;
			end
			if (s1_move) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			take_word_s1 <= do_get;
			status_s1    <= status_nx;
			occ_s1       <= cnt_nx;
			delay_s1     <= delay_nx;
		end
		if (s1_move) begin
			out_data_q <= {delay_s1, occ_s1, status_s1, take_word_s1 ? rd_word : '0};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

### rtl/core/forc_store.sv
`timescale 1ns / 1ps
// Message word memory: one write port, one read port, registered read data.
// Depends on forc_pkg for depth and word width.
module forc_store (
	input  logic                          clk,
	input  logic                          we,
	input  logic [forc_pkg::PTR_W-1:0]    waddr,
	input  logic [forc_pkg::WORD_W-1:0]   wdata,
	input  logic                          re,
	input  logic [forc_pkg::PTR_W-1:0]    raddr,
	output logic [forc_pkg::WORD_W-1:0]   rdata
);
	import forc_pkg::*;

	logic [WORD_W-1:0] mem [QUEUE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the message FIFO with occupancy-driven delay control.
// Needs forc_pkg and fifo_with_occupancy_rate_control_core; runs directed then random items.
module tb_top;
	import forc_pkg::*;

	// mode 3 is not an operation; the block reports its state and does nothing
	localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;
	localparam int CFG_ANY   = -1;	// any 32-bit write value
	localparam int CFG_MILD  = -2;	// moderate value so plain steps happen
	localparam int HOLD_LEN  = 300;
	localparam int NUM_PHASE = 6;
	localparam int PHASE_OPS = 85;

	// field order mirrors m_tdata, lowest field last
	typedef struct packed {
		logic [DELAY_W-1:0]  delay;
		logic [CNT_W-1:0]    occ;
		logic [STATUS_W-1:0] status;
		logic [WORD_W-1:0]   word;
	} fifo_result_t;

	typedef struct {
		logic [MODE_W-1:0] mode;
		logic [WORD_W-1:0] word;
		int                reps;
		bit                rnd_word;
		bit                typed;
		fifo_result_t      want;
	} op_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;	// [1:0] mode, [33:2] write_word, rest zero
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;	// [31:0] read_word, [33:32] status, [39:34] occupancy,
					// [63:40] current_delay
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	fifo_with_occupancy_rate_control_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#400000;
		$display("tb_top: errors");
		$finish;
	end

	// shadow of the block: message store, pointers, fill count, delay, registers
	logic [WORD_W-1:0]  shadow_msgs [QUEUE_DEPTH];
	logic [PTR_W-1:0]   shadow_rd = '0;
	logic [PTR_W-1:0]   shadow_wr = '0;
	int                 shadow_fill = 0;
	logic [DELAY_W-1:0] shadow_delay = RST_DELAY;
	logic [THR_W-1:0]   cfg_thresh = RST_THRESHOLD;
	logic [DELAY_W-1:0] cfg_step = RST_STEP;
	logic [DELAY_W-1:0] cfg_floor_trg = RST_FLOOR_TRG;
	logic [DELAY_W-1:0] cfg_floor_val = RST_FLOOR_VAL;
	logic [DELAY_W-1:0] cfg_ceiling = RST_CEILING;

	fifo_result_t pending_results [$];
	int mismatches = 0;
	int tx_idle_pct = 7;
	int rx_idle_pct = 67;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;

	op_row_t dir_ops [21] = '{
		'{MODE_GET,    32'h0000_0000, 1, 0, 1, '{24'd500000, 6'd0, ST_EMPTY, 32'h0}},
		'{MODE_ADJUST, 32'hFFFF_FFFF, 1, 0, 1, '{24'd200000, 6'd0, ST_DONE, 32'h0}},
		// step exceeds delay: snaps to floor
		'{MODE_ADJUST, 32'h0000_0000, 1, 0, 1, '{24'd50000, 6'd0, ST_DONE, 32'h0}},
		'{MODE_NOP,    32'hFFFF_FFFF, 1, 0, 1, '{24'd50000, 6'd0, ST_DONE, 32'h0}},
		'{MODE_PUT,    32'h7FFF_FFFF, 1, 0, 1, '{24'd50000, 6'd1, ST_DONE, 32'h0}},
		'{MODE_PUT,    32'h8000_0000, 1, 0, 1, '{24'd50000, 6'd2, ST_DONE, 32'h0}},
		'{MODE_PUT,    32'h0000_0000, 1, 0, 1, '{24'd50000, 6'd3, ST_DONE, 32'h0}},
		'{MODE_PUT,    32'hFFFF_FFFF, 1, 0, 1, '{24'd50000, 6'd4, ST_DONE, 32'h0}},
		'{MODE_PUT,    32'h0000_0000, 28, 1, 0, '0},
		'{MODE_PUT,    32'h5555_5555, 1, 0, 1, '{24'd50000, 6'd32, ST_FULL, 32'h0}},
		'{MODE_ADJUST, 32'h0000_0000, 1, 0, 1, '{24'd350000, 6'd32, ST_DONE, 32'h0}},
		// climbs into the ceiling
		'{MODE_ADJUST, 32'h0000_0000, 6, 1, 0, '0},
		'{MODE_GET,    32'h0000_0000, 1, 0, 1, '{24'd2000000, 6'd31, ST_DONE, 32'h7FFF_FFFF}},
		'{MODE_GET,    32'h0000_0000, 1, 0, 1, '{24'd2000000, 6'd30, ST_DONE, 32'h8000_0000}},
		'{MODE_GET,    32'h0000_0000, 1, 0, 1, '{24'd2000000, 6'd29, ST_DONE, 32'h0}},
		'{MODE_GET,    32'h0000_0000, 1, 0, 1, '{24'd2000000, 6'd28, ST_DONE, 32'hFFFF_FFFF}},
		'{MODE_NOP,    32'h0000_0000, 1, 1, 0, '0},
		'{MODE_GET,    32'h0000_0000, 28, 1, 0, '0},
		'{MODE_GET,    32'h0000_0000, 1, 0, 1, '{24'd2000000, 6'd0, ST_EMPTY, 32'h0}},
		'{MODE_PUT,    32'hAAAA_AAAA, 1, 0, 0, '0},
		'{MODE_ADJUST, 32'h0000_0000, 1, 0, 1, '{24'd1700000, 6'd1, ST_DONE, 32'h0}}
	};

	// threshold, step, floor trigger, floor value, ceiling per random phase
	int cfg_plan [NUM_PHASE][5] = '{
		'{10, 300000, 100000, 50000, 2000000},
		'{0, 'hFFFFFF, 0, 0, 'hFFFFFF},
		'{63, 1, 'hFFFFFF, 'hFFFFFF, 1000},	// floor above ceiling
		'{20, 0, 0, 7, 1000},			// delay starts above ceiling
		'{5, CFG_ANY, CFG_ANY, CFG_ANY, 0},
		'{CFG_ANY, CFG_MILD, CFG_MILD, CFG_ANY, CFG_ANY}
	};

	function automatic fifo_result_t apply_fifo_op(logic [MODE_W-1:0] mode,
			logic [WORD_W-1:0] word);
		fifo_result_t r;
		logic [DELAY_W:0] sum;
		r = '0;
		r.status = ST_DONE;
		case (mode)
			MODE_PUT: begin
				if (shadow_fill >= QUEUE_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					shadow_msgs[shadow_wr] = word;
					shadow_wr = shadow_wr + 1'b1;
					shadow_fill++;
				end
			end
			MODE_GET: begin
				if (shadow_fill == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.word = shadow_msgs[shadow_rd];
					shadow_rd = shadow_rd + 1'b1;
					shadow_fill--;
				end
			end
			MODE_ADJUST: begin
				if (shadow_fill < int'(cfg_thresh)) begin
					if (cfg_step > shadow_delay || shadow_delay - cfg_step < cfg_floor_trg)
						shadow_delay = cfg_floor_val;
					else
						shadow_delay = shadow_delay - cfg_step;
				end else begin
					sum = {1'b0, shadow_delay} + {1'b0, cfg_step};
					if (sum > {1'b0, cfg_ceiling})
						sum = {1'b0, cfg_ceiling};
					shadow_delay = sum[DELAY_W-1:0];
				end
			end
			default: ;
		endcase
		r.occ = CNT_W'(shadow_fill);
		r.delay = shadow_delay;
		return r;
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_THRESHOLD: cfg_thresh = value[THR_W-1:0];
			REG_STEP:      cfg_step = value[DELAY_W-1:0];
			REG_FLOOR_TRG: cfg_floor_trg = value[DELAY_W-1:0];
			REG_FLOOR_VAL: cfg_floor_val = value[DELAY_W-1:0];
			REG_CEILING:   cfg_ceiling = value[DELAY_W-1:0];
			default: ;
		endcase
	endtask

	// offer one item until taken; typed rows supply their own expectation
	task automatic send_op(logic [MODE_W-1:0] mode, logic [WORD_W-1:0] word, bit typed,
			fifo_result_t want);
		fifo_result_t predicted;
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_W-MODE_W-WORD_W){1'b0}}, word, mode};
		do @(posedge clk); while (!s_tready);
		predicted = apply_fifo_op(mode, word);
		pending_results.push_back(typed ? want : predicted);
		if ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
	endtask

	task automatic drain_results();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	function automatic logic [DATA_W-1:0] cfg_value(int plan);
		if (plan == CFG_ANY)
			return $urandom;
		if (plan == CFG_MILD)
			return $urandom_range(0, 400000);
		return plan;
	endfunction

	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(15))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h7FFF_FFFF;
			3: return 32'h8000_0000;
			default: return $urandom;
		endcase
	endfunction

	// bursts that lean toward filling or toward draining, so full and empty both occur
	function automatic logic [MODE_W-1:0] pick_mode(bit filling);
		int r;
		r = $urandom_range(99);
		if (r >= 96)
			return MODE_NOP;
		if (r >= 80)
			return MODE_ADJUST;
		if (filling)
			return (r < 55) ? MODE_PUT : MODE_GET;
		return (r < 25) ? MODE_PUT : MODE_GET;
	endfunction

	always @(posedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served <= hold_requests;
			hold_left <= HOLD_LEN;
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin : check_results
		fifo_result_t got;
		fifo_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result word %h status %0d occ %0d delay %0d",
						$realtime, got.word, got.status, got.occ, got.delay);
			end else begin
				want = pending_results.pop_front();
				if (got.word !== want.word || got.status !== want.status ||
						got.occ !== want.occ || got.delay !== want.delay) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: exp word %h st %0d occ %0d dly %0d, got word %h st %0d occ %0d dly %0d",
							$realtime, want.word, want.status, want.occ, want.delay,
							got.word, got.status, got.occ, got.delay);
				end
			end
		end
	end

	initial begin : stimulus
		bit filling;
		int run_left;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_ops[i]) begin
			for (int k = 0; k < dir_ops[i].reps; k++)
				send_op(dir_ops[i].mode, dir_ops[i].rnd_word ? $urandom : dir_ops[i].word,
					dir_ops[i].typed, dir_ops[i].want);
		end
		s_tvalid <= 1'b0;

		filling = 1'b1;
		run_left = $urandom_range(20, 60);
		for (int p = 0; p < NUM_PHASE; p++) begin
			drain_results();
			if (p == 2) begin
				tx_idle_pct = 67;
				rx_idle_pct = 7;
			end else if (p == 4) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			write_reg(REG_THRESHOLD, cfg_value(cfg_plan[p][0]));
			write_reg(REG_STEP, cfg_value(cfg_plan[p][1]));
			write_reg(REG_FLOOR_TRG, cfg_value(cfg_plan[p][2]));
			write_reg(REG_FLOOR_VAL, cfg_value(cfg_plan[p][3]));
			write_reg(REG_CEILING, cfg_value(cfg_plan[p][4]));
			// long output stall while items keep coming, so the input backs up
			if (p == 4)
				hold_requests <= hold_requests + 1;
			for (int n = 0; n < PHASE_OPS; n++) begin
				if (--run_left == 0) begin
					filling = !filling;
					run_left = $urandom_range(20, 60);
				end
				send_op(pick_mode(filling), pick_word(), 1'b0, '0);
			end
			s_tvalid <= 1'b0;
		end

		drain_results();
		if (mismatches == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
